/* rtl/pbosc_pkg.sv */
// shared types, codes and constants for the polyblep oscillator
// no dependencies; imported by every module of the block
package pbosc_pkg;

  // default sizes
  localparam int DEF_SINE_DEPTH  = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // pi/2 in q30, used to build the quarter sine table
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // operation codes of an input transaction
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // waveform codes
  localparam logic [1:0] WAVE_SINE = 2'd0;
  localparam logic [1:0] WAVE_TRI  = 2'd1;
  localparam logic [1:0] WAVE_SAW  = 2'd2;
  localparam logic [1:0] WAVE_PULSE = 2'd3;

  // register indexes on the config port
  localparam logic [2:0] REG_WAVEFORM = 3'd0;
  localparam logic [2:0] REG_PULSE_WIDTH = 3'd1;
  localparam logic [2:0] REG_LEVEL = 3'd2;
  localparam logic [2:0] REG_TUNE = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;

  // register reset values
  localparam logic [15:0] RST_PULSE_WIDTH = 16'd32768;
  localparam logic [15:0] RST_LEVEL = 16'd32768;
  localparam logic [18:0] RST_TUNE = 19'd65536;
  localparam logic [31:0] RST_PERIOD = 32'd22906492;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_STOP
  } pbosc_kind_t;

  // classified item handed from front to back
  typedef struct packed {
    pbosc_kind_t kind;
    logic [15:0] velocity;
    logic [22:0] frequency;
    logic        end_of_block;
  } pbosc_item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [1:0]  waveform_select;
    logic [15:0] pulse_width;
    logic [15:0] output_level;
    logic [18:0] tune_ratio;
    logic [31:0] sample_period;
  } pbosc_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST0,
    S_ST1,
    S_ST2,
    S_ST3,
    S_DIV,
    S_SIN_MUL,
    S_SIN_RD,
    S_SIN_VAL,
    S_BL_MUL,
    S_BL_SQ,
    S_BL_ACC,
    S_SC1,
    S_SC2,
    S_OUT
  } pbosc_state_t;

endpackage

/* rtl/pbosc_front.sv */
// front end: accepts input transactions, classifies them, queues them
// depends on pbosc_pkg
module pbosc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [15:0]        note_velocity,
  input  logic [22:0]        note_frequency,
  input  logic               end_of_block,
  output pbosc_pkg::pbosc_item_t q_item,
  output logic               q_valid,
  input  logic               q_pop
);
  import pbosc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  pbosc_item_t    entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           accept;
  logic           push;
  logic           keep;
  pbosc_item_t    item_in;

  // classify the operation; the unused code is dropped
  always_comb begin
    keep = 1'b1;
    item_in.velocity = note_velocity;
    item_in.frequency = note_frequency;
    item_in.end_of_block = end_of_block;
    case (operation)
      OP_TICK:  item_in.kind = KIND_TICK;
      OP_START: item_in.kind = KIND_START;
      OP_STOP:  item_in.kind = KIND_STOP;
      default: begin
        item_in.kind = KIND_TICK;
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (count == (PW+1)'(QUEUE_DEPTH));
  assign accept = in_valid & ~in_stall;
  assign push = accept & keep;
  assign q_valid = (count != '0);
  assign q_item = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

endmodule

/* rtl/pbosc_back.sv */
// back end: sequencer around one shared multiplier, reciprocal divider,
// quarter sine rom, output register; depends on pbosc_pkg
module pbosc_back #(
  parameter int SINE_TABLE_DEPTH = pbosc_pkg::DEF_SINE_DEPTH,
  parameter int SAMPLE_BITS = pbosc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pbosc_pkg::pbosc_cfg_t         cfg,
  input  pbosc_pkg::pbosc_item_t        q_item,
  input  logic                          q_valid,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] audio_sample,
  output logic                          last_of_block
);
  import pbosc_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int SH = 46 - SAMPLE_BITS;
  localparam logic [49:0] LIM_POS = 50'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [49:0] LIM_NEG = 50'(64'd1 << (SAMPLE_BITS - 1));

  // quarter sine table built at elaboration (taylor series in q30)
  logic [14:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned X = (longint'(gi) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X * X2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned T7 = ((T6 * X2) >> 30) / 210;
    localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                           + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
    localparam longint unsigned SP = (SUM < 0) ? 64'd0 : longint'(SUM);
    localparam longint unsigned V = (SP * 64'd32767 + (64'd1 << 29)) >> 30;
    localparam longint unsigned VC = (V > 64'd32767) ? 64'd32767 : V;
    assign sine_rom[gi] = 15'(VC);
  end

  pbosc_state_t state, state_next;

  // oscillator state
  logic [31:0] phase_acc;
  logic [31:0] phase_step;
  logic [31:0] step_reciprocal;
  logic [15:0] held_velocity;
  logic        is_playing;

  // working registers
  logic [22:0] cur_freq;
  logic [15:0] cur_vel;
  logic        cur_eob;
  logic [65:0] prod;
  logic [9:0]  frhi;
  logic [31:0] lopart;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [5:0]  cnt;
  logic signed [18:0] s_acc;
  logic        blep_idx;
  logic        blep_sub;
  logic        blep_lo;
  logic [1:0]  quad;
  logic        sin_special;
  logic [14:0] rom_data;

  // shared multiplier operands
  logic [33:0] mul_a;
  logic [31:0] mul_b;

  // combinational helpers
  logic [31:0] pw32;
  logic [31:0] t_val;
  logic [32:0] wrap_dist;
  logic        in_lo;
  logic        in_hi;
  logic        blep_on;
  logic        more_blep;
  logic [15:0] u_cap;
  logic [15:0] d_val;
  logic signed [18:0] corr;
  logic [42:0] st_sum;
  logic [31:0] st_sat;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [AW-1:0] k_idx;
  logic [AW:0]   mirror;
  logic [AW-1:0] rom_addr;
  logic signed [15:0] saw;
  logic signed [18:0] saw_abs;
  logic [17:0] s_mag;
  logic [49:0] scaled;
  logic [49:0] mag_sat;
  logic [SAMPLE_BITS-1:0] res_mag;
  logic        out_hold;

  assign out_hold = out_valid & out_stall;

  // blep region tests and correction terms
  assign pw32 = {cfg.pulse_width, 16'b0};
  assign t_val = blep_idx ? (phase_acc - pw32) : phase_acc;
  assign wrap_dist = 33'h1_0000_0000 - {1'b0, t_val};
  assign in_lo = (t_val < phase_step);
  assign in_hi = (wrap_dist < {1'b0, phase_step});
  assign blep_on = (phase_step != '0) & (in_lo | in_hi);
  assign more_blep = (cfg.waveform_select == WAVE_PULSE) & ~blep_idx;
  assign u_cap = (prod[63:33] > 31'd32768) ? 16'd32768 : prod[48:33];
  assign d_val = 16'd32768 - u_cap;
  assign corr = ((blep_lo ^ blep_sub) ? -19'sd1 : 19'sd1) * $signed({3'b0, prod[30:15]});

  // phase step sum, saturated at one half
  assign st_sum = {1'b0, prod[41:0]} + {11'b0, lopart};
  assign st_sat = (st_sum > 43'h0_8000_0000) ? 32'h8000_0000 : st_sum[31:0];

  // reciprocal divider step
  assign rem_sh = {rem, (cnt == '0)};
  assign div_ge = (rem_sh >= {1'b0, phase_step});

  // sine addressing
  assign k_idx = prod[30 +: AW];
  assign mirror = (AW+1)'(SINE_TABLE_DEPTH) - {1'b0, k_idx};
  assign rom_addr = quad[0] ? mirror[AW-1:0] : k_idx;

  // raw waves
  assign saw = {~phase_acc[31], phase_acc[30:16]};
  assign saw_abs = saw[15] ? -19'(saw) : 19'(saw);

  // scaling and saturation
  assign s_mag = s_acc[18] ? 18'(-s_acc) : 18'(s_acc);
  assign scaled = prod[49:0] >> SH;
  always_comb begin
    if (s_acc[18]) begin
      mag_sat = (scaled > LIM_NEG) ? LIM_NEG : scaled;
    end else begin
      mag_sat = (scaled > LIM_POS) ? LIM_POS : scaled;
    end
  end
  assign res_mag = mag_sat[SAMPLE_BITS-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, queue pop and multiplier operands
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            KIND_START: state_next = S_ST0;
            KIND_TICK: begin
              if (!is_playing) begin
                state_next = S_SC1;
              end else begin
                case (cfg.waveform_select)
                  WAVE_SINE: state_next = S_SIN_MUL;
                  WAVE_TRI:  state_next = S_SC1;
                  default:   state_next = S_BL_MUL;
                endcase
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ST0: begin
        mul_a = {11'b0, cur_freq};
        mul_b = {13'b0, cfg.tune_ratio};
        state_next = S_ST1;
      end
      S_ST1: begin
        mul_a = {2'b0, prod[31:0]};
        mul_b = cfg.sample_period;
        state_next = S_ST2;
      end
      S_ST2: begin
        mul_a = {24'b0, frhi};
        mul_b = cfg.sample_period;
        state_next = S_ST3;
      end
      S_ST3: begin
        if (st_sat <= 32'h0001_0000) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == 6'd48) begin
          state_next = S_IDLE;
        end
      end
      S_SIN_MUL: begin
        mul_a = {4'b0, phase_acc[29:0]};
        mul_b = 32'(SINE_TABLE_DEPTH);
        state_next = S_SIN_RD;
      end
      S_SIN_RD: state_next = S_SIN_VAL;
      S_SIN_VAL: state_next = S_SC1;
      S_BL_MUL: begin
        mul_a = {2'b0, in_lo ? t_val : wrap_dist[31:0]};
        mul_b = step_reciprocal;
        if (blep_on) begin
          state_next = S_BL_SQ;
        end else if (more_blep) begin
          state_next = S_BL_MUL;
        end else begin
          state_next = S_SC1;
        end
      end
      S_BL_SQ: begin
        mul_a = {18'b0, d_val};
        mul_b = {16'b0, d_val};
        state_next = S_BL_ACC;
      end
      S_BL_ACC: begin
        state_next = more_blep ? S_BL_MUL : S_SC1;
      end
      S_SC1: begin
        mul_a = {16'b0, s_mag};
        mul_b = {16'b0, cfg.output_level};
        state_next = S_SC2;
      end
      S_SC2: begin
        mul_a = prod[33:0];
        mul_b = {16'b0, held_velocity};
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_hold) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // shared multiplier and rom read; the scaled product holds while the result waits
  always_ff @(posedge clk) begin
    if (state != S_OUT) begin
      prod <= mul_a * mul_b;
    end
    rom_data <= sine_rom[rom_addr];
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur_freq <= q_item.frequency;
        cur_vel <= q_item.velocity;
        cur_eob <= q_item.end_of_block;
        blep_idx <= 1'b0;
        blep_sub <= (cfg.waveform_select == WAVE_SAW);
        if (!is_playing) begin
          s_acc <= '0;
        end else begin
          case (cfg.waveform_select)
            WAVE_TRI:   s_acc <= (saw_abs <<< 1) - 19'sd32768;
            WAVE_SAW:   s_acc <= 19'(saw);
            WAVE_PULSE: s_acc <= (phase_acc < pw32) ? 19'sd32768 : -19'sd32768;
            default:    s_acc <= '0;
          endcase
        end
      end
      S_ST1: frhi <= prod[41:32];
      S_ST2: lopart <= prod[63:32];
      S_SIN_MUL: quad <= phase_acc[31:30];
      S_SIN_RD: sin_special <= quad[0] & (k_idx == '0);
      S_SIN_VAL: begin
        if (quad[1]) begin
          s_acc <= sin_special ? -19'sd32767 : -$signed({4'b0, rom_data});
        end else begin
          s_acc <= sin_special ? 19'sd32767 : $signed({4'b0, rom_data});
        end
      end
      S_BL_MUL: begin
        blep_lo <= in_lo;
        if (!blep_on && more_blep) begin
          blep_idx <= 1'b1;
          blep_sub <= 1'b1;
        end
      end
      S_BL_ACC: begin
        s_acc <= s_acc + corr;
        if (more_blep) begin
          blep_idx <= 1'b1;
          blep_sub <= 1'b1;
        end
      end
      S_ST3: begin
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end
      S_DIV: begin
        rem <= div_ge ? 32'(rem_sh - {1'b0, phase_step}) : rem_sh[31:0];
        quo <= {quo[30:0], div_ge};
        cnt <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

  // oscillator state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      phase_step <= '0;
      step_reciprocal <= '0;
      held_velocity <= '0;
      is_playing <= 1'b0;
    end else begin
      if (state == S_IDLE && q_valid && q_item.kind == KIND_STOP) begin
        is_playing <= 1'b0;
      end
      if (state == S_ST3) begin
        phase_step <= st_sat;
        held_velocity <= cur_vel;
        phase_acc <= '0;
        is_playing <= 1'b1;
        if (st_sat == '0) begin
          step_reciprocal <= '0;
        end else if (st_sat <= 32'h0001_0000) begin
          step_reciprocal <= '1;
        end
      end
      if (state == S_DIV && cnt == 6'd48) begin
        step_reciprocal <= {quo[30:0], div_ge};
      end
      if (state == S_OUT && !out_hold && is_playing) begin
        phase_acc <= phase_acc + phase_step;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && !out_hold) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && !out_hold) begin
      audio_sample <= s_acc[18] ? -$signed(res_mag) : $signed(res_mag);
      last_of_block <= cur_eob;
    end
  end

endmodule

/* rtl/polyblep_multiwave_oscillator_unit.sv */
// top level of the polyblep oscillator: config registers and apb port,
// front queue and back sequencer; depends on pbosc_pkg, pbosc_front, pbosc_back
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    operation, note_velocity,
//                                            note_frequency, end_of_block
//  out       output     out_valid/out_stall  audio_sample, last_of_block
//  config    input      apb psel/penable     paddr, pwdata, prdata
//
// a tick steps through the one shared multiplier: stopped and triangle ticks
// go straight to scaling, sine adds a table read, saw adds one polyblep
// correction and pulse up to two. a start runs three multiplies and a sum,
// then a 49-step bit-serial reciprocal divider, which is skipped when the
// reciprocal saturates. a stop is handled in the idle state.
// synchronous reset clears control and oscillator state; the sine rom is
// constant. a stalled output holds in its register while the front queue
// (two transactions) keeps accepting until it is full.
module polyblep_multiwave_oscillator_unit #(
  parameter int SINE_TABLE_DEPTH = pbosc_pkg::DEF_SINE_DEPTH,
  parameter int SAMPLE_BITS = pbosc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [15:0]                   note_velocity,
  input  logic [22:0]                   note_frequency,
  input  logic                          end_of_block,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] audio_sample,
  output logic                          last_of_block,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pbosc_pkg::*;

  pbosc_cfg_t  cfg;
  pbosc_item_t q_item;
  logic        q_valid;
  logic        q_pop;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel & penable & pwrite & pready;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform_select <= WAVE_SINE;
      cfg.pulse_width <= RST_PULSE_WIDTH;
      cfg.output_level <= RST_LEVEL;
      cfg.tune_ratio <= RST_TUNE;
      cfg.sample_period <= RST_PERIOD;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WAVEFORM:    cfg.waveform_select <= pwdata[1:0];
        REG_PULSE_WIDTH: cfg.pulse_width <= pwdata[15:0];
        REG_LEVEL:       cfg.output_level <= pwdata[15:0];
        REG_TUNE:        cfg.tune_ratio <= pwdata[18:0];
        REG_PERIOD:      cfg.sample_period <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_WAVEFORM:    prdata = {30'b0, cfg.waveform_select};
      REG_PULSE_WIDTH: prdata = {16'b0, cfg.pulse_width};
      REG_LEVEL:       prdata = {16'b0, cfg.output_level};
      REG_TUNE:        prdata = {13'b0, cfg.tune_ratio};
      REG_PERIOD:      prdata = cfg.sample_period;
      default:         prdata = '0;
    endcase
  end

  pbosc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .note_velocity  (note_velocity),
    .note_frequency (note_frequency),
    .end_of_block   (end_of_block),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  pbosc_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .audio_sample  (audio_sample),
    .last_of_block (last_of_block)
  );

endmodule

/* tb/tb_scoreboard.sv */
// scoreboard for the polyblep oscillator testbench: sample predictor and checker
// depends on pbosc_pkg for operation, waveform and register codes and reset values
`timescale 1ns / 1ps

class osc_scoreboard;
  // configuration copy
  logic [1:0]  wave_sel;
  logic [15:0] pw_reg;
  logic [15:0] level_reg;
  logic [18:0] tune_reg;
  logic [31:0] period_reg;
  // oscillator state copy
  logic [31:0] phase;
  logic [31:0] step;
  logic [31:0] recip;
  logic [15:0] velocity;
  bit          playing;
  logic [15:0] quarter_sine [1024];
  // pending samples
  logic [15:0] sample_q [$];
  bit          last_q [$];
  int          errors;
  int          checked;

  function new();
    errors = 0;
    checked = 0;
    build_sine();
    reset_state();
  endfunction

  function void reset_state();
    wave_sel = pbosc_pkg::WAVE_SINE;
    pw_reg = pbosc_pkg::RST_PULSE_WIDTH;
    level_reg = pbosc_pkg::RST_LEVEL;
    tune_reg = pbosc_pkg::RST_TUNE;
    period_reg = pbosc_pkg::RST_PERIOD;
    phase = 0;
    step = 0;
    recip = 0;
    velocity = 0;
    playing = 0;
  endfunction

  // quarter sine via taylor series in q30
  function void build_sine();
    longint unsigned x, x2, term, v;
    longint sum;
    for (int i = 0; i < 1024; i++) begin
      x = (longint'(i) * pbosc_pkg::HALF_PI_Q30) / 1024;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k & 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      quarter_sine[i] = v[15:0];
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      pbosc_pkg::REG_WAVEFORM:    wave_sel = val[1:0];
      pbosc_pkg::REG_PULSE_WIDTH: pw_reg = val[15:0];
      pbosc_pkg::REG_LEVEL:       level_reg = val[15:0];
      pbosc_pkg::REG_TUNE:        tune_reg = val[18:0];
      pbosc_pkg::REG_PERIOD:      period_reg = val;
      default: ;
    endcase
  endfunction

  // polyblep residual at phase t
  function int blep_corr(logic [31:0] t);
    longint unsigned u, d, wrap_dist;
    if (step == 0) return 0;
    if (t < step) begin
      u = (longint'(t) * recip) >> 33;
      if (u > 32768) u = 32768;
      d = 32768 - u;
      return -int'((d * d) >> 15);
    end
    wrap_dist = 64'h1_0000_0000 - t;
    if (wrap_dist < step) begin
      u = (wrap_dist * recip) >> 33;
      if (u > 32768) u = 32768;
      d = 32768 - u;
      return int'((d * d) >> 15);
    end
    return 0;
  endfunction

  function int sine_at(logic [31:0] p);
    logic [1:0] quad;
    int k, v;
    quad = p[31:30];
    k = int'((longint'(p[29:0]) * 1024) >> 30);
    if (quad[0]) v = (k == 0) ? 32767 : quarter_sine[1024 - k];
    else v = quarter_sine[k];
    return quad[1] ? -v : v;
  endfunction

  // note an accepted input transaction
  function void note_input(logic [1:0] op, logic [15:0] vel, logic [22:0] freq, bit eob);
    longint unsigned fr, st, r, mag;
    int s, saw;
    logic [31:0] pwx;
    logic [15:0] res;
    if (op == pbosc_pkg::OP_START) begin
      fr = longint'(freq) * tune_reg;
      st = (fr >> 32) * period_reg + (((fr & 64'hFFFF_FFFF) * period_reg) >> 32);
      if (st > 64'h8000_0000) st = 64'h8000_0000;
      step = st[31:0];
      if (st == 0) recip = 0;
      else begin
        r = (64'd1 << 48) / st;
        recip = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
      end
      velocity = vel;
      phase = 0;
      playing = 1;
    end else if (op == pbosc_pkg::OP_STOP) begin
      playing = 0;
    end else if (op == pbosc_pkg::OP_TICK) begin
      res = 0;
      if (playing) begin
        saw = int'(phase >> 16) - 32768;
        case (wave_sel)
          pbosc_pkg::WAVE_SINE: s = sine_at(phase);
          pbosc_pkg::WAVE_TRI:  s = 2 * (saw < 0 ? -saw : saw) - 32768;
          pbosc_pkg::WAVE_SAW:  s = saw - blep_corr(phase);
          default: begin
            pwx = {pw_reg, 16'h0};
            s = (phase < pwx) ? 32768 : -32768;
            s += blep_corr(phase);
            s -= blep_corr(phase - pwx);
          end
        endcase
        mag = longint'(s < 0 ? -s : s);
        mag = (mag * level_reg * velocity) >> 30;
        if (s < 0) begin
          if (mag > 32768) mag = 32768;
          res = -mag[15:0];
        end else begin
          if (mag > 32767) mag = 32767;
          res = mag[15:0];
        end
        phase = phase + step;
      end
      sample_q.push_back(res);
      last_q.push_back(eob);
    end
  endfunction

  // compare one output transaction with the oldest pending sample
  function void check_output(logic [15:0] smp, bit last);
    checked++;
    if (sample_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected sample, expected none actual %0d", $time, $signed(smp));
      return;
    end
    if (sample_q[0] !== smp) begin
      errors++;
      $display("%0t: audio_sample expected %0d actual %0d", $time,
               $signed(sample_q[0]), $signed(smp));
    end
    if (last_q[0] !== last) begin
      errors++;
      $display("%0t: last_of_block expected %0d actual %0d", $time, last_q[0], last);
    end
    void'(sample_q.pop_front());
    void'(last_q.pop_front());
  endfunction
endclass

/* tb/tb.sv */
// top of the polyblep oscillator testbench: clock, reset, drivers, phases
// depends on pbosc_pkg, osc_scoreboard and polyblep_multiwave_oscillator_unit
`timescale 1ns / 1ps

module tb;
  // operation code with no meaning, dropped by the block
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  operation = 0;
  logic [15:0] note_velocity = 0;
  logic [22:0] note_frequency = 0;
  logic        end_of_block = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic signed [15:0] audio_sample;
  logic        last_of_block;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  osc_scoreboard board;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_off = 0;
  longint cycles = 0;
  int  sent_items = 0;

  polyblep_multiwave_oscillator_unit dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_output(audio_sample, last_of_block);
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off counted here
  task automatic hold_receiver(int n);
    hold_off <= 1'b1;
    repeat (n) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // offer one input transaction and wait for acceptance
  task automatic send_item(logic [1:0] op, logic [15:0] vel, logic [22:0] freq, bit eob);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    note_velocity <= vel;
    note_frequency <= freq;
    end_of_block <= eob;
    // stall only changes at the rising edge, so sample it mid-cycle
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    board.note_input(op, vel, freq, eob);
    sent_items++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // wait for every pending sample, then for the block to finish queued starts
  task automatic drain();
    in_valid <= 1'b0;
    while (board.sample_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [15:0] vel;
    logic [22:0] freq;
    bit eob;
    r = $urandom_range(99);
    vel = 16'($urandom);
    freq = 23'($urandom);
    eob = 1'($urandom_range(1));
    if (r < 80) send_item(pbosc_pkg::OP_TICK, vel, freq, eob);
    else if (r < 90) begin
      if ($urandom_range(3) != 0) begin
        vel = 16'($urandom_range(32768));
        freq = 23'($urandom_range(20000 * 256));
      end
      send_item(pbosc_pkg::OP_START, vel, freq, eob);
    end else if (r < 95) send_item(pbosc_pkg::OP_STOP, vel, freq, eob);
    else send_item(OP_SPARE, vel, freq, eob);
  endtask

  // random config then a run of items
  task automatic random_phase(int n);
    drain();
    write_reg(pbosc_pkg::REG_WAVEFORM, $urandom);
    write_reg(pbosc_pkg::REG_PULSE_WIDTH, $urandom);
    write_reg(pbosc_pkg::REG_LEVEL, $urandom_range(32768));
    write_reg(pbosc_pkg::REG_TUNE, $urandom_range(16384, 262144));
    write_reg(pbosc_pkg::REG_PERIOD, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 26));
    send_item(pbosc_pkg::OP_START, 16'($urandom_range(32768)),
              23'($urandom_range(20000 * 256)), 1'b0);
    repeat (n) random_item();
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: stopped tick, reset config, each waveform, extremes
    send_item(pbosc_pkg::OP_TICK, 16'hFFFF, 23'h7FFFFF, 1'b1);
    send_item(pbosc_pkg::OP_START, 16'd32768, 23'(440 * 256), 1'b0);
    repeat (3) send_item(pbosc_pkg::OP_TICK, 16'd0, 23'd0, 1'b0);
    send_item(OP_SPARE, 16'hFFFF, 23'h7FFFFF, 1'b1);
    for (int w = 0; w < 4; w++) begin
      drain();
      write_reg(pbosc_pkg::REG_WAVEFORM, w);
      write_reg(pbosc_pkg::REG_PULSE_WIDTH, (w == 3) ? 32'hFFFF : 32'd0);
      write_reg(pbosc_pkg::REG_LEVEL, 32'd32768);
      write_reg(pbosc_pkg::REG_TUNE, (w & 1) ? 32'd262144 : 32'd16384);
      write_reg(pbosc_pkg::REG_PERIOD, (w == 2) ? 32'hFFFFFFFF : 32'd1);
      send_item(pbosc_pkg::OP_START, (w == 3) ? 16'hFFFF : 16'd32768, 23'h7FFFFF, 1'b1);
      send_item(pbosc_pkg::OP_TICK, 16'd0, 23'd0, 1'b1);
      send_item(pbosc_pkg::OP_TICK, 16'd0, 23'd0, 1'b0);
    end
    send_item(pbosc_pkg::OP_START, 16'd0, 23'd0, 1'b0);
    send_item(pbosc_pkg::OP_TICK, 16'd0, 23'd0, 1'b1);
    send_item(pbosc_pkg::OP_STOP, 16'd0, 23'd0, 1'b0);
    send_item(pbosc_pkg::OP_TICK, 16'd0, 23'd0, 1'b0);

    // random phases with changing idle patterns
    random_phase(90);
    send_idle_pct = 49;
    random_phase(90);
    send_idle_pct = 0;
    stall_pct = 49;
    random_phase(90);
    send_idle_pct = 12;
    stall_pct = 12;
    random_phase(90);
    // receiver holds off while the sender keeps offering ticks
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    fork
      hold_receiver(300);
      repeat (20) send_item(pbosc_pkg::OP_TICK, 16'd0, 23'd0, 1'($urandom_range(1)));
    join
    random_phase(60);

    drain();
    $display("run covered %0d input transactions and %0d samples", sent_items, board.checked);
    $display("all waveforms, register extremes, idle and stall phases, long hold-off");
    if (board.errors == 0 && board.sample_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
